// ----- hdl/smtp_client_sequencer_macros.svh -----
// Assertion macros for the SMTP client sequencer.
`ifndef SMTP_CLIENT_SEQUENCER_MACROS_SVH
`define SMTP_CLIENT_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define SCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hdl/smtpcs_pkg.sv -----
// Shared types, codes and helpers for the SMTP client sequencer.
package smtpcs_pkg;

    localparam int MAX_RCPT_DEFAULT    = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [3:0] ST_GREET = 4'd0;
    localparam logic [3:0] ST_HELO  = 4'd1;
    localparam logic [3:0] ST_EHLO  = 4'd2;
    localparam logic [3:0] ST_AUTH  = 4'd3;
    localparam logic [3:0] ST_USER  = 4'd4;
    localparam logic [3:0] ST_PASS  = 4'd5;
    localparam logic [3:0] ST_MAIL  = 4'd6;
    localparam logic [3:0] ST_RCPT  = 4'd7;
    localparam logic [3:0] ST_DATA  = 4'd8;
    localparam logic [3:0] ST_BODY  = 4'd9;
    localparam logic [3:0] ST_EOM   = 4'd10;
    localparam logic [3:0] ST_QUIT  = 4'd11;
    localparam logic [3:0] ST_CLOSE = 4'd12;

    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_BODY = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [3:0] CMD_HELO = 4'd0;
    localparam logic [3:0] CMD_EHLO = 4'd1;
    localparam logic [3:0] CMD_AUTH = 4'd2;
    localparam logic [3:0] CMD_USER = 4'd3;
    localparam logic [3:0] CMD_PASS = 4'd4;
    localparam logic [3:0] CMD_MAIL = 4'd5;
    localparam logic [3:0] CMD_RCPT = 4'd6;
    localparam logic [3:0] CMD_DATA = 4'd7;
    localparam logic [3:0] CMD_EOM  = 4'd8;
    localparam logic [3:0] CMD_QUIT = 4'd9;

    localparam logic [1:0] MODE_REPLY = 2'd0;
    localparam logic [1:0] MODE_BODY  = 2'd1;
    localparam logic [1:0] MODE_EOB   = 2'd2;

    localparam logic [9:0] CODE_READY   = 10'd220;
    localparam logic [9:0] CODE_OK      = 10'd250;
    localparam logic [9:0] CODE_AUTH    = 10'd334;
    localparam logic [9:0] CODE_AUTH_OK = 10'd235;
    localparam logic [9:0] CODE_DATA    = 10'd354;
    localparam logic [9:0] CODE_BYE     = 10'd221;

    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_DOT  = 8'd46;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;

    localparam logic ADDR_USE_AUTH = 1'b0;
    localparam logic ADDR_RCPT_CNT = 1'b1;

    typedef struct packed {
        logic       use_auth;
        logic [4:0] recipient_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] command;
        logic [3:0] recipient_index;
        logic [9:0] reply_code;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [9:0] expected_code(input logic [3:0] st);
        logic [9:0] c;
        unique case (st) inside
            ST_GREET:         c = CODE_READY;
            ST_AUTH, ST_USER: c = CODE_AUTH;
            ST_PASS:          c = CODE_AUTH_OK;
            ST_DATA:          c = CODE_DATA;
            ST_QUIT:          c = CODE_BYE;
            default:          c = CODE_OK;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/smtpcs_queue.sv -----
// Short queue between the classify front and the output back end.
module smtpcs_queue import smtpcs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output qstat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/smtpcs_front.sv -----
// Front end: reply parsing, session stage tracking and body byte escaping.
module smtpcs_front import smtpcs_pkg::*; #(
    parameter int MAX_RECIPIENTS = MAX_RCPT_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [1:0] in_mode,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    input  cfg_t       cfg,
    output logic       push,
    output entry_t     push_entry
);

    localparam int CNT_MAX = (MAX_RECIPIENTS < 31) ? MAX_RECIPIENTS : 31;
    localparam int CW      = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
    localparam logic [4:0] CAP = 5'(CNT_MAX);

    logic [3:0]    stage_reg, stage_next;
    logic [CW-1:0] rcpt_cnt_reg, rcpt_cnt_next;
    logic [1:0]    digit_cnt_reg, digit_cnt_next;
    logic [9:0]    line_code_reg, line_code_next;
    logic          stopped_reg, stopped_next;
    logic          body_sol_reg, body_sol_next;

    logic          finish;
    logic          is_digit;
    logic [3:0]    digit;
    logic [9:0]    code_mul;
    logic [9:0]    code_chk;
    logic [4:0]    rc_min;
    logic [4:0]    eff;
    logic [5:0]    cnt_inc;
    entry_t        e;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = 4'(in_byte - CH_ZERO);
    assign code_mul = 10'(line_code_reg * 10'd10) + 10'(digit);
    assign rc_min   = (cfg.recipient_count == '0) ? 5'd1 : cfg.recipient_count;
    assign eff      = (rc_min > CAP) ? CAP : rc_min;
    assign cnt_inc  = 6'(rcpt_cnt_reg) + 6'd1;

    always_comb begin
        stage_next     = stage_reg;
        rcpt_cnt_next  = rcpt_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        line_code_next = line_code_reg;
        stopped_next   = stopped_reg;
        body_sol_next  = body_sol_reg;
        finish         = 1'b0;
        code_chk       = line_code_reg;
        push           = 1'b0;
        e              = '0;

        if (in_accept) begin
            unique case (in_mode)
                MODE_REPLY: begin
                    if (stage_reg != ST_BODY && stage_reg < ST_CLOSE) begin
                        if (in_byte == CH_LF) begin
                            if (in_end) begin
                                finish = 1'b1;
                            end else begin
                                digit_cnt_next = '0;
                                line_code_next = '0;
                                stopped_next   = 1'b0;
                            end
                        end else begin
                            if (digit_cnt_reg < 2'd3) begin
                                digit_cnt_next = digit_cnt_reg + 2'd1;
                                if (!stopped_reg && is_digit) begin
                                    line_code_next = code_mul;
                                end else begin
                                    stopped_next = 1'b1;
                                end
                            end
                            finish = in_end;
                        end
                    end
                end
                MODE_BODY: begin
                    if (stage_reg == ST_BODY) begin
                        e.kind = KIND_BODY;
                        if (in_byte == CH_LF) begin
                            push          = 1'b1;
                            e.byte0       = CH_CR;
                            e.byte1       = CH_LF;
                            e.two         = 1'b1;
                            body_sol_next = 1'b1;
                        end else begin
                            body_sol_next = 1'b0;
                            if (body_sol_reg && in_byte == CH_DOT) begin
                                push    = 1'b1;
                                e.byte0 = CH_DOT;
                                e.byte1 = CH_DOT;
                                e.two   = 1'b1;
                            end else if (in_byte != CH_CR) begin
                                push    = 1'b1;
                                e.byte0 = in_byte;
                            end
                        end
                    end
                end
                MODE_EOB: begin
                    if (stage_reg == ST_BODY) begin
                        push       = 1'b1;
                        e.kind     = KIND_CMD;
                        e.command  = CMD_EOM;
                        stage_next = ST_EOM;
                    end
                end
                default: begin
                end
            endcase
        end

        if (finish) begin
            code_chk       = line_code_next;
            digit_cnt_next = '0;
            line_code_next = '0;
            stopped_next   = 1'b0;
            e.kind         = KIND_CMD;
            e.reply_code   = code_chk;
            push           = 1'b1;
            if (code_chk != expected_code(stage_reg)) begin
                e.kind     = KIND_FAIL;
                stage_next = ST_CLOSE;
            end else begin
                unique case (stage_reg) inside
                    ST_GREET: begin
                        if (cfg.use_auth) begin
                            e.command  = CMD_EHLO;
                            stage_next = ST_EHLO;
                        end else begin
                            e.command  = CMD_HELO;
                            stage_next = ST_HELO;
                        end
                    end
                    ST_HELO, ST_PASS: begin
                        e.command     = CMD_MAIL;
                        stage_next    = ST_MAIL;
                        rcpt_cnt_next = '0;
                    end
                    ST_EHLO: begin
                        e.command  = CMD_AUTH;
                        stage_next = ST_AUTH;
                    end
                    ST_AUTH: begin
                        e.command  = CMD_USER;
                        stage_next = ST_USER;
                    end
                    ST_USER: begin
                        e.command  = CMD_PASS;
                        stage_next = ST_PASS;
                    end
                    ST_MAIL: begin
                        e.command         = CMD_RCPT;
                        e.recipient_index = 4'(rcpt_cnt_reg);
                        if (cnt_inc >= {1'b0, eff}) begin
                            stage_next = ST_RCPT;
                        end else begin
                            rcpt_cnt_next = rcpt_cnt_reg + CW'(1);
                        end
                    end
                    ST_RCPT: begin
                        e.command  = CMD_DATA;
                        stage_next = ST_DATA;
                    end
                    ST_DATA: begin
                        push          = 1'b0;
                        stage_next    = ST_BODY;
                        body_sol_next = 1'b1;
                    end
                    ST_EOM: begin
                        e.command  = CMD_QUIT;
                        stage_next = ST_QUIT;
                    end
                    default: begin
                        e.kind     = KIND_DONE;
                        stage_next = ST_CLOSE;
                    end
                endcase
            end
        end
        push_entry = e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg     <= ST_GREET;
            rcpt_cnt_reg  <= '0;
            digit_cnt_reg <= '0;
            line_code_reg <= '0;
            stopped_reg   <= 1'b0;
            body_sol_reg  <= 1'b1;
        end else begin
            stage_reg     <= stage_next;
            rcpt_cnt_reg  <= rcpt_cnt_next;
            digit_cnt_reg <= digit_cnt_next;
            line_code_reg <= line_code_next;
            stopped_reg   <= stopped_next;
            body_sol_reg  <= body_sol_next;
        end
    end

endmodule

// ----- hdl/smtpcs_back.sv -----
// Back end: turns queued entries into result beats on a registered output.
module smtpcs_back import smtpcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  entry_t     head,
    input  qstat_t     qstat,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [1:0] out_kind,
    output logic [3:0] out_command,
    output logic [3:0] out_rcpt,
    output logic [7:0] out_byte,
    output logic [9:0] out_code,
    output logic       out_last
);

    logic       valid_reg, valid_next;
    logic       pend_reg, pend_next;
    logic [7:0] pend_byte_reg;
    logic [1:0] kind_reg;
    logic [3:0] command_reg;
    logic [3:0] rcpt_reg;
    logic [7:0] byte_reg;
    logic [9:0] code_reg;
    logic       last_reg;
    logic       advance;

    assign advance = !valid_reg || out_ready;
    assign pop     = advance && !pend_reg && !qstat.empty;

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        if (advance) begin
            if (pend_reg) begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
            end else if (!qstat.empty) begin
                valid_next = 1'b1;
                pend_next  = head.two;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (pend_reg) begin
                kind_reg    <= KIND_BODY;
                command_reg <= '0;
                rcpt_reg    <= '0;
                byte_reg    <= pend_byte_reg;
                code_reg    <= '0;
                last_reg    <= 1'b1;
            end else if (!qstat.empty) begin
                kind_reg      <= head.kind;
                command_reg   <= head.command;
                rcpt_reg      <= head.recipient_index;
                byte_reg      <= head.byte0;
                code_reg      <= head.reply_code;
                last_reg      <= !head.two;
                pend_byte_reg <= head.byte1;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_command = command_reg;
    assign out_rcpt    = rcpt_reg;
    assign out_byte    = byte_reg;
    assign out_code    = code_reg;
    assign out_last    = last_reg;

endmodule

// ----- hdl/smtp_client_sequencer.sv -----
// SMTP client sequencer top level: config registers, front, queue and back end.
// Path: the accepting edge writes the queue; the back end then loads the output register.
// Throughput: one input beat per cycle; a two-beat body result holds the output until
// both beats are taken, and when the queue is full s_tready stays low until an entry leaves.
// Reset: synchronous active-low; clears session state, config to defaults,
// empties the queue and drops any pending output beat.
`include "smtp_client_sequencer_macros.svh"
module smtp_client_sequencer import smtpcs_pkg::*; #(
    parameter int MAX_RECIPIENTS = MAX_RCPT_DEFAULT,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] command, [7:4] recipient_index,
                                   // [15:8] body_byte, [25:16] reply_code
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       use_auth_reg;
    logic [4:0] rcpt_count_reg;
    cfg_t       cfg;
    logic       cfg_wr;
    logic       in_accept;
    logic       push;
    entry_t     push_entry;
    entry_t     head;
    qstat_t     qstat;
    logic       pop;
    logic [3:0] out_command;
    logic [3:0] out_rcpt;
    logic [7:0] out_byte;
    logic [9:0] out_code;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_auth_reg   <= 1'b0;
            rcpt_count_reg <= 5'd1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                ADDR_USE_AUTH: use_auth_reg   <= pwdata[0];
                ADDR_RCPT_CNT: rcpt_count_reg <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    assign prdata = (paddr[2] == ADDR_RCPT_CNT) ? {27'd0, rcpt_count_reg}
                                                : {31'd0, use_auth_reg};

    assign cfg.use_auth        = use_auth_reg;
    assign cfg.recipient_count = rcpt_count_reg;

    assign s_tready  = !qstat.full;
    assign in_accept = s_tvalid && s_tready;

    smtpcs_front #(
        .MAX_RECIPIENTS(MAX_RECIPIENTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_mode   (s_tuser),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .cfg       (cfg),
        .push      (push),
        .push_entry(push_entry)
    );

    smtpcs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    smtpcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_kind   (m_tuser),
        .out_command(out_command),
        .out_rcpt   (out_rcpt),
        .out_byte   (out_byte),
        .out_code   (out_code),
        .out_last   (m_tlast)
    );

    assign m_tdata = {6'd0, out_code, out_byte, out_rcpt, out_command};

    // only escaped body bytes come in pairs
    `SCS_ASSERT_IMP(a_pair_is_body, aclk, aresetn, m_tvalid && !m_tlast, m_tuser == KIND_BODY, "non-last beat is not a body byte")
    // second beat of a pair follows at once
    `SCS_ASSERT_NXT(a_pair_back_to_back, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser == KIND_BODY, "second beat of pair missing")
    // nothing follows a failure or session end
    `SCS_ASSERT_NXT(a_closed_quiet, aclk, aresetn, m_tvalid && m_tready && (m_tuser == KIND_FAIL || m_tuser == KIND_DONE), !m_tvalid, "beat after session closed")

endmodule
